[rtl/m3inv_pkg.sv]
// Shared types and constants for the 3x3 matrix inverse pipeline.
package m3inv_pkg;

  localparam int ElemWidth = 32;
  localparam int FracBits  = 16;

  typedef struct packed {
    logic signed [ElemWidth-1:0] in_r1c1;
    logic signed [ElemWidth-1:0] in_r1c2;
    logic signed [ElemWidth-1:0] in_r1c3;
    logic signed [ElemWidth-1:0] in_r2c1;
    logic signed [ElemWidth-1:0] in_r2c2;
    logic signed [ElemWidth-1:0] in_r2c3;
    logic signed [ElemWidth-1:0] in_r3c1;
    logic signed [ElemWidth-1:0] in_r3c2;
    logic signed [ElemWidth-1:0] in_r3c3;
  } m3inv_in_t;

  typedef struct packed {
    logic signed [ElemWidth-1:0] out_r1c1;
    logic signed [ElemWidth-1:0] out_r1c2;
    logic signed [ElemWidth-1:0] out_r1c3;
    logic signed [ElemWidth-1:0] out_r2c1;
    logic signed [ElemWidth-1:0] out_r2c2;
    logic signed [ElemWidth-1:0] out_r2c3;
    logic signed [ElemWidth-1:0] out_r3c1;
    logic signed [ElemWidth-1:0] out_r3c2;
    logic signed [ElemWidth-1:0] out_r3c3;
    logic                        singular;
    logic                        overflow;
  } m3inv_out_t;

endpackage

[rtl/m3inv_div.sv]
// Pipelined restoring divider: one quotient bit per stage, one divide per cycle while adv_i is high.
module m3inv_div #(
  parameter int NumW = 8,
  parameter int DenW = 8,
  parameter int TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            vld_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic            vld_o,
  output logic [NumW-1:0] quo_o,
  output logic [TagW-1:0] tag_o
);

  // Remainder never exceeds the divisor, so one extra bit covers the shift.
  localparam int RemW = DenW + 1;

  logic [NumW:0]          vld_q;
  logic [NumW:0][NumW-1:0] num_q;
  logic [NumW:0][RemW-1:0] rem_q;
  logic [NumW:0][DenW-1:0] den_q;
  logic [NumW:0][TagW-1:0] tag_q;

  always_comb begin
    vld_q[0] = vld_i;
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    tag_q[0] = tag_i;
  end

  for (genvar s = 0; s < NumW; s++) begin : g_stage
    logic [RemW-1:0] shf;
    logic [RemW:0]   dif;
    logic [RemW-1:0] rem_d;
    logic [NumW-1:0] num_d;
    logic            vld_r;
    logic [NumW-1:0] num_r;
    logic [RemW-1:0] rem_r;
    logic [DenW-1:0] den_r;
    logic [TagW-1:0] tag_r;

    always_comb begin
      shf   = {rem_q[s][RemW-2:0], num_q[s][NumW-1]};
      dif   = {1'b0, shf} - {2'b00, den_q[s]};
      rem_d = dif[RemW] ? shf : dif[RemW-1:0];
      num_d = {num_q[s][NumW-2:0], ~dif[RemW]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_r <= 1'b0;
      end else if (adv_i) begin
        vld_r <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        num_r <= num_d;
        rem_r <= rem_d;
        den_r <= den_q[s];
        tag_r <= tag_q[s];
      end
    end

    always_comb begin
      vld_q[s+1] = vld_r;
      num_q[s+1] = num_r;
      rem_q[s+1] = rem_r;
      den_q[s+1] = den_r;
      tag_q[s+1] = tag_r;
    end
  end

  assign vld_o = vld_q[NumW];
  assign quo_o = num_q[NumW];
  assign tag_o = tag_q[NumW];

endmodule

[rtl/matrix3x3_inverse_top.sv]
// Top level of the 3x3 matrix inverse: adjugate, determinant, nine dividers, saturation.
// Registers: input, products, cofactors, determinant partials, determinant, magnitudes,
// dividers (2*ElemWidth + 2*FRAC_BITS + 1 stages), output register; Q16.16 by default.
// Throughput: one request per cycle; the whole pipe moves together, gated by out stall.
// The nine bit-serial-stage dividers set the depth: one quotient bit per stage.
// Reset: asynchronous active low; clears every valid bit, payload registers hold no reset.
module matrix3x3_inverse_top #(
  parameter int FRAC_BITS  = m3inv_pkg::FracBits
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  m3inv_pkg::m3inv_in_t   in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output m3inv_pkg::m3inv_out_t  out_data_o
);

  localparam int EW  = m3inv_pkg::ElemWidth;
  localparam int PW  = 2 * EW;       // one element product
  localparam int AW  = PW + 1;       // cofactor
  localparam int LW  = AW - EW;      // low cofactor slice for the determinant products
  localparam int DW  = AW + EW + 2;  // determinant sum
  localparam int NW  = AW + 2 * FRAC_BITS; // shifted magnitude numerator

  // Advance the pipe whenever the output register is free or being drained.
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // Stage 1: register the input matrix.
  logic                        v1_q;
  logic signed [8:0][EW-1:0]   m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q[0] <= in_data_i.in_r1c1;
      m_q[1] <= in_data_i.in_r1c2;
      m_q[2] <= in_data_i.in_r1c3;
      m_q[3] <= in_data_i.in_r2c1;
      m_q[4] <= in_data_i.in_r2c2;
      m_q[5] <= in_data_i.in_r2c3;
      m_q[6] <= in_data_i.in_r3c1;
      m_q[7] <= in_data_i.in_r3c2;
      m_q[8] <= in_data_i.in_r3c3;
    end
  end

  // Stage 2: the eighteen element products of the cofactors.
  logic                        v2_q;
  logic signed [PW-1:0]        pa_q [9];
  logic signed [PW-1:0]        pb_q [9];
  logic signed [EW-1:0]        m2_q [3];

  // Index pairs: cofactor k = m[A0]*m[A1] - m[B0]*m[B1].
  localparam int IA0 [9] = '{4, 2, 1, 5, 0, 3, 3, 6, 0};
  localparam int IA1 [9] = '{8, 7, 5, 6, 8, 2, 7, 1, 4};
  localparam int IB0 [9] = '{7, 1, 2, 3, 2, 0, 6, 0, 3};
  localparam int IB1 [9] = '{5, 8, 4, 8, 6, 5, 4, 7, 1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_prod
    always_ff @(posedge clk_i) begin
      if (adv) begin
        pa_q[k] <= PW'($signed(m_q[IA0[k]]) * $signed(m_q[IA1[k]]));
        pb_q[k] <= PW'($signed(m_q[IB0[k]]) * $signed(m_q[IB1[k]]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_q[0] <= m_q[0];
      m2_q[1] <= m_q[1];
      m2_q[2] <= m_q[2];
    end
  end

  // Stage 3: cofactors.
  logic                 v3_q;
  logic signed [AW-1:0] adj_q [9];
  logic signed [EW-1:0] m3_q  [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_adj
    always_ff @(posedge clk_i) begin
      if (adv) begin
        adj_q[k] <= AW'(pa_q[k]) - AW'(pb_q[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m3_q <= m2_q;
    end
  end

  // Stage 4: determinant partial products (first row against first cofactor column).
  // Split each cofactor into a signed high slice and an unsigned low slice so that
  // every multiplier stays about EW x EW bits.
  localparam int IDT [3] = '{0, 3, 6};

  logic                     v4_q;
  logic signed [EW+LW:0]    dpl_q [3];
  logic signed [2*EW-1:0]   dph_q [3];
  logic signed [AW-1:0]     adj4_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_det
    logic signed [LW:0]   alo;
    logic signed [EW-1:0] ahi;
    assign alo = {1'b0, adj_q[IDT[k]][LW-1:0]};
    assign ahi = adj_q[IDT[k]][AW-1:LW];
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dpl_q[k] <= (EW+LW+1)'(m3_q[k]) * (EW+LW+1)'(alo);
        dph_q[k] <= (2*EW)'(m3_q[k]) * (2*EW)'(ahi);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      adj4_q <= adj_q;
    end
  end

  // Stage 5: determinant.
  logic                 v5_q;
  logic signed [DW-1:0] det_q;
  logic signed [AW-1:0] adj5_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_q  <= ((DW'(dph_q[0]) + DW'(dph_q[1]) + DW'(dph_q[2])) <<< LW)
                + DW'(dpl_q[0]) + DW'(dpl_q[1]) + DW'(dpl_q[2]);
      adj5_q <= adj4_q;
    end
  end

  // Stage 6: magnitudes and signs for the dividers.
  logic            v6_q;
  logic [DW-1:0]   dmag_q;
  logic            dzero_q;
  logic [NW-1:0]   nmag_q [9];
  logic [8:0]      neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_mag
    logic [AW-1:0] amag;
    assign amag = adj5_q[k][AW-1] ? AW'(-adj5_q[k]) : AW'(adj5_q[k]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nmag_q[k] <= NW'(amag) << (2 * FRAC_BITS);
        neg_q[k]  <= adj5_q[k][AW-1] ^ det_q[DW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dmag_q  <= det_q[DW-1] ? DW'(-det_q) : DW'(det_q);
      dzero_q <= (det_q == '0);
    end
  end

  // Dividers: nine lanes, the sign and singular flag ride along in every lane's tag.
  localparam int TW = 2;
  logic [8:0]          qv;
  logic [NW-1:0]       quo [9];
  logic [TW-1:0]       tag [9];

  for (genvar k = 0; k < 9; k++) begin : g_div
    m3inv_div #(
      .NumW (NW),
      .DenW (DW),
      .TagW (TW)
    ) u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .vld_i  (v6_q),
      .num_i  (nmag_q[k]),
      .den_i  (dmag_q),
      .tag_i  ({dzero_q, neg_q[k]}),
      .vld_o  (qv[k]),
      .quo_o  (quo[k]),
      .tag_o  (tag[k])
    );
  end

  // Final stage: saturate, sign, flag; this is the output register.
  localparam logic [NW-1:0] Half = NW'(1) << (EW - 1);

  logic [EW-1:0] res   [9];
  logic [8:0]    sat;
  logic          sing;

  assign sing = tag[0][1];

  for (genvar k = 0; k < 9; k++) begin : g_sat
    always_comb begin
      sat[k] = 1'b0;
      if (tag[k][0]) begin
        if (quo[k] > Half) begin
          sat[k] = 1'b1;
          res[k] = Half[EW-1:0];
        end else begin
          res[k] = EW'(-quo[k][EW-1:0]);
        end
      end else begin
        if (quo[k] >= Half) begin
          sat[k] = 1'b1;
          res[k] = EW'(Half[EW-1:0] - EW'(1));
        end else begin
          res[k] = quo[k][EW-1:0];
        end
      end
      if (sing) begin
        sat[k] = 1'b0;
        res[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= qv[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_o.out_r1c1 <= res[0];
      out_data_o.out_r1c2 <= res[1];
      out_data_o.out_r1c3 <= res[2];
      out_data_o.out_r2c1 <= res[3];
      out_data_o.out_r2c2 <= res[4];
      out_data_o.out_r2c3 <= res[5];
      out_data_o.out_r3c1 <= res[6];
      out_data_o.out_r3c2 <= res[7];
      out_data_o.out_r3c3 <= res[8];
      out_data_o.singular <= sing;
      out_data_o.overflow <= |sat;
    end
  end

endmodule

[tb/matrix3x3_inverse_top_tb.sv]
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
module matrix3x3_inverse_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Wide enough for the adjugate shifted by 2*FracBits and its quotient.
  typedef logic signed [255:0] wide_t;

  localparam int Latency    = 7 + 2 * m3inv_pkg::ElemWidth + 2 * m3inv_pkg::FracBits;
  localparam int WatchLimit = 20000;
  localparam int NumRandom  = 800;
  localparam logic signed [m3inv_pkg::ElemWidth-1:0] MaxElem =
    {1'b0, {(m3inv_pkg::ElemWidth-1){1'b1}}};
  localparam logic signed [m3inv_pkg::ElemWidth-1:0] MinElem =
    {1'b1, {(m3inv_pkg::ElemWidth-1){1'b0}}};
  localparam logic signed [m3inv_pkg::ElemWidth-1:0] One     = 1 << m3inv_pkg::FracBits;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  m3inv_pkg::m3inv_in_t  in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  m3inv_pkg::m3inv_out_t out_data_o;

  matrix3x3_inverse_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected inverses, oldest first.
  m3inv_pkg::m3inv_out_t inverse_q[$];
  int         err_cnt = 0;
  int         done_cnt = 0;
  int         singular_cnt = 0;
  int         overflow_cnt = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Truncated, saturated quotient adj * 2^(2F) / det for one element.
  function automatic logic [m3inv_pkg::ElemWidth-1:0] scaled_quotient(input wide_t adj,
                                                                      input wide_t det,
                                                                      inout logic ovf);
    wide_t q;
    q = (adj <<< (2 * m3inv_pkg::FracBits)) / det;
    if (q > wide_t'(MaxElem)) begin
      ovf = 1'b1;
      return MaxElem;
    end
    if (q < wide_t'(MinElem)) begin
      ovf = 1'b1;
      return MinElem;
    end
    return q[m3inv_pkg::ElemWidth-1:0];
  endfunction

  function automatic m3inv_pkg::m3inv_out_t invert_matrix(input m3inv_pkg::m3inv_in_t m);
    wide_t                 e [9];
    wide_t                 a [9];
    wide_t                 det;
    logic                  ovf;
    m3inv_pkg::m3inv_out_t r;
    e[0] = m.in_r1c1; e[1] = m.in_r1c2; e[2] = m.in_r1c3;
    e[3] = m.in_r2c1; e[4] = m.in_r2c2; e[5] = m.in_r2c3;
    e[6] = m.in_r3c1; e[7] = m.in_r3c2; e[8] = m.in_r3c3;
    a[0] = e[4] * e[8] - e[7] * e[5];
    a[1] = e[2] * e[7] - e[1] * e[8];
    a[2] = e[1] * e[5] - e[2] * e[4];
    a[3] = e[5] * e[6] - e[3] * e[8];
    a[4] = e[0] * e[8] - e[2] * e[6];
    a[5] = e[3] * e[2] - e[0] * e[5];
    a[6] = e[3] * e[7] - e[6] * e[4];
    a[7] = e[6] * e[1] - e[0] * e[7];
    a[8] = e[0] * e[4] - e[3] * e[1];
    det = e[0] * a[0] + e[1] * a[3] + e[2] * a[6];
    r = '0;
    if (det == 0) begin
      r.singular = 1'b1;
      return r;
    end
    ovf = 1'b0;
    r.out_r1c1 = scaled_quotient(a[0], det, ovf);
    r.out_r1c2 = scaled_quotient(a[1], det, ovf);
    r.out_r1c3 = scaled_quotient(a[2], det, ovf);
    r.out_r2c1 = scaled_quotient(a[3], det, ovf);
    r.out_r2c2 = scaled_quotient(a[4], det, ovf);
    r.out_r2c3 = scaled_quotient(a[5], det, ovf);
    r.out_r3c1 = scaled_quotient(a[6], det, ovf);
    r.out_r3c2 = scaled_quotient(a[7], det, ovf);
    r.out_r3c3 = scaled_quotient(a[8], det, ovf);
    r.overflow = ovf;
    return r;
  endfunction

  // Random element: mostly values near unity so the inverse stays in range,
  // sometimes full-range bits, sometimes an extreme, zero or a tiny raw value.
  function automatic logic [m3inv_pkg::ElemWidth-1:0] rand_elem();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return ($urandom_range(1)) ? MaxElem : MinElem;
      2:       return '0;
      3:       return $signed($urandom_range(8)) - 4;
      default: return $signed($urandom_range(2 * 8 * One)) - 8 * One;
    endcase
  endfunction

  function automatic m3inv_pkg::m3inv_in_t rand_matrix();
    m3inv_pkg::m3inv_in_t m;
    m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
         rand_elem(), rand_elem(), rand_elem(), rand_elem()};
    // Make some singular on purpose: copy one row into another.
    if ($urandom_range(9) == 0) begin
      m.in_r3c1 = m.in_r1c1;
      m.in_r3c2 = m.in_r1c2;
      m.in_r3c3 = m.in_r1c3;
    end
    return m;
  endfunction

  // Directed rows; a typed-in expectation is used where has_result is set.
  typedef struct {
    m3inv_pkg::m3inv_in_t  mat;
    logic                  has_result;
    m3inv_pkg::m3inv_out_t result;
  } directed_row_t;

  directed_row_t directed_tbl [$];

  function automatic m3inv_pkg::m3inv_in_t diag(input logic [m3inv_pkg::ElemWidth-1:0] d0,
                                                input logic [m3inv_pkg::ElemWidth-1:0] d1,
                                                input logic [m3inv_pkg::ElemWidth-1:0] d2);
    m3inv_pkg::m3inv_in_t m;
    m = '0;
    m.in_r1c1 = d0; m.in_r2c2 = d1; m.in_r3c3 = d2;
    return m;
  endfunction

  task automatic build_table();
    m3inv_pkg::m3inv_out_t r;
    m3inv_pkg::m3inv_in_t  m;
    // All zero: singular, everything zero.
    r = '0; r.singular = 1'b1;
    directed_tbl.push_back('{'0, 1'b1, r});
    // Every element at max or min, and all ones: rows equal, so singular.
    directed_tbl.push_back('{{9{MaxElem}}, 1'b1, r});
    directed_tbl.push_back('{{9{MinElem}}, 1'b1, r});
    directed_tbl.push_back('{{9{32'hFFFF_FFFF}}, 1'b1, r});
    // Identity inverts to identity.
    r = '0; r.out_r1c1 = One; r.out_r2c2 = One; r.out_r3c3 = One;
    directed_tbl.push_back('{diag(One, One, One), 1'b1, r});
    // Tiny diagonal: inverse saturates high.
    r = '0; r.out_r1c1 = MaxElem; r.out_r2c2 = MaxElem; r.out_r3c3 = MaxElem;
    r.overflow = 1'b1;
    directed_tbl.push_back('{diag(1, 1, 1), 1'b1, r});
    // Tiny negative diagonal: saturates low.
    r = '0; r.out_r1c1 = MinElem; r.out_r2c2 = MinElem; r.out_r3c3 = MinElem;
    r.overflow = 1'b1;
    directed_tbl.push_back('{diag('1, '1, '1), 1'b1, r});
    // Remaining rows go through the predictor.
    directed_tbl.push_back('{diag(-One, 2 * One, One / 2), 1'b0, '0});
    directed_tbl.push_back('{diag(MaxElem, MinElem, MaxElem), 1'b0, '0});
    directed_tbl.push_back('{diag(MinElem, MinElem, MinElem), 1'b0, '0});
    directed_tbl.push_back('{diag(One / 2, One / 2, One / 2), 1'b0, '0});
    m = diag(One, One, One); m.in_r1c2 = MaxElem; m.in_r2c3 = MinElem;
    directed_tbl.push_back('{m, 1'b0, '0});
    m = '{in_r1c1: 2 * One, in_r1c2: One, in_r1c3: 0, in_r2c1: One, in_r2c2: 3 * One,
          in_r2c3: -One, in_r3c1: 0, in_r3c2: One, in_r3c3: 4 * One};
    directed_tbl.push_back('{m, 1'b0, '0});
    // Truncation toward zero on negative quotients.
    directed_tbl.push_back('{diag(3 * One, -3 * One, 7 * One), 1'b0, '0});
    m = '{in_r1c1: MaxElem, in_r1c2: MinElem, in_r1c3: 1, in_r2c1: -1, in_r2c2: MaxElem,
          in_r2c3: MinElem, in_r3c1: 2, in_r3c2: -2, in_r3c3: MaxElem};
    directed_tbl.push_back('{m, 1'b0, '0});
    directed_tbl.push_back('{{9{32'h5555_AAAA}}, 1'b0, '0});
    directed_tbl.push_back('{diag(32'h5555_5555, 32'hAAAA_AAAA, 32'h0001_0001), 1'b0, '0});
  endtask

  // Drive one request and hold it until accepted; record its expectation.
  task automatic send_request(input m3inv_pkg::m3inv_in_t m, input logic has_result,
                              input m3inv_pkg::m3inv_out_t r);
    // Drop valid while idling so the previous request is not sent again.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    inverse_q.push_back(has_result ? r : invert_matrix(m));
    // Hold valid high if another request follows; the caller drops it at the end.
  endtask

  // Receiver stall, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    m3inv_pkg::m3inv_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (inverse_q.size() == 0) begin
        err_cnt++;
        $display("%t: unexpected result %h", $time, out_data_o);
      end else begin
        want = inverse_q.pop_front();
        done_cnt++;
        if (want.singular) singular_cnt++;
        if (want.overflow) overflow_cnt++;
        if (out_data_o !== want) begin
          err_cnt++;
          $display("%t: mismatch expected %h actual %h", $time, want, out_data_o);
        end
      end
    end
  end

  // Watchdog: advance the idle count on cycles where nothing is accepted.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("matrix3x3_inverse_top_tb failed");
      $finish;
    end
  end

  initial begin
    int phase;
    build_table();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 87 : 0;
      recv_idle_pct = (phase == 0) ? 87 : (phase == 1) ? 18 : 0;
      if (phase == 0) begin
        foreach (directed_tbl[i])
          send_request(directed_tbl[i].mat, directed_tbl[i].has_result,
                       directed_tbl[i].result);
      end
      for (int n = 0; n < NumRandom / 3; n++) send_request(rand_matrix(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    recv_idle_pct = 0;
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("Checked %0d inverses: %0d singular, %0d saturated.",
             done_cnt, singular_cnt, overflow_cnt);
    if (err_cnt == 0) $display("matrix3x3_inverse_top_tb passed");
    else $display("matrix3x3_inverse_top_tb failed");
    $finish;
  end

endmodule
